>>> hdl/swqt_pkg.sv
// shared types and codes of the semaphore wait queue table
`default_nettype none
package swqt_pkg;

    localparam int CMD_W     = 2;
    localparam int KEY_IN_W  = 32;
    localparam int PROC_ID_W = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_BLOCK  = 2'd0,
        CMD_WAKE   = 2'd1,
        CMD_CANCEL = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ACT,
        ST_LINK,
        ST_WAKE_NX,
        ST_CX_RDP,
        ST_CX_RDD,
        ST_CX_WALK,
        ST_DONE
    } state_t;

endpackage
`default_nettype wire

>>> hdl/swqt_if.sv
// request and response channel interfaces
`default_nettype none
interface swqt_req_if;
    logic                           valid;
    logic                           ready;
    logic [swqt_pkg::CMD_W-1:0]     cmd;
    logic [swqt_pkg::KEY_IN_W-1:0]  sem_key;
    logic [swqt_pkg::PROC_ID_W-1:0] proc_id;

    modport source (output valid, cmd, sem_key, proc_id, input ready);
    modport sink (input valid, cmd, sem_key, proc_id, output ready);
endinterface

interface swqt_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           proc_valid;
    logic [swqt_pkg::PROC_ID_W-1:0] out_proc;
    logic                           table_full;

    modport source (output valid, proc_valid, out_proc, table_full, input ready);
    modport sink (input valid, proc_valid, out_proc, table_full, output ready);
endinterface
`default_nettype wire

>>> hdl/semaphore_wait_queue_table.sv
// semaphore wait queue table: descriptor pool with per-key fifo of blocked processes
//
// req carries one command beat (cmd, sem_key, proc_id); rsp returns exactly one
// result beat per command (proc_valid, out_proc, table_full), in order.
// one command is worked at a time; req.ready is high only while idle.
// block, wake and query scan the descriptor memory one entry per cycle; a hit ends
// the scan early. cancel reads the process entry, then its descriptor, then walks
// the queue from its head one link per cycle up to the predecessor of the process;
// a process at the head of its queue needs no walk.
// block and cancel with a bad or ignored process id go straight to the result stage.
// the result sits in an output register; a stalled rsp holds it, and the next
// command is taken while it waits, its own result held back until the slot frees.
// reset clears the active and blocked flags; the memories need no clearing.
`default_nettype none
module semaphore_wait_queue_table #(
    parameter int NUM_PROCS = 32,
    parameter int KEY_WIDTH = 32
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    swqt_req_if.sink    req,
    swqt_rsp_if.source  rsp
);
    import swqt_pkg::*;

    localparam int PW = $clog2(NUM_PROCS);
    localparam int CW = PW + 1;
    localparam int XW = (PW > PROC_ID_W) ? PW : PROC_ID_W;
    localparam int YW = (KEY_WIDTH > KEY_IN_W) ? KEY_WIDTH : KEY_IN_W;
    localparam int DW = KEY_WIDTH + 2 * PW;
    localparam int QW = 2 * PW;

    // descriptor memory: key | head | tail ; process memory: next | desc
    logic [DW-1:0] dmem [NUM_PROCS];
    logic [QW-1:0] pmem [NUM_PROCS];
    logic [DW-1:0] dq_reg;
    logic [QW-1:0] pq_reg;

    state_t state_reg, state_next;
    cmd_t   cmd_reg, cmd_next;
    logic [KEY_WIDTH-1:0] key_reg, key_next;
    logic [PW-1:0] p_reg, p_next, d_reg, d_next, head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next, pn_reg, pn_next, q_reg, q_next;
    logic [PW-1:0] chk_reg, chk_next, free_reg, free_next, res_p_reg, res_p_next;
    logic [CW-1:0] sc_reg, sc_next;
    logic chk_vld_reg, chk_vld_next, free_ok_reg, free_ok_next, hit_reg, hit_next;
    logic res_v_reg, res_v_next, res_f_reg, res_f_next;
    logic out_v_reg, out_v_next, out_pv_reg, out_pv_next, out_f_reg, out_f_next;
    logic [PROC_ID_W-1:0] out_p_reg, out_p_next;
    logic [NUM_PROCS-1:0] active_reg, active_next, blocked_reg, blocked_next;

    logic [PW-1:0] d_raddr, d_waddr, d_whead, d_wtail, p_raddr, p_waddr, p_wnxt, p_wdsc;
    logic d_we_key, d_we_head, d_we_tail, p_we_nxt, p_we_dsc;

    logic [XW-1:0] pid_ext, res_ext;
    logic [YW-1:0] key_ext;
    logic [PW-1:0] p_idx, dq_head, dq_tail, pq_nxt, pq_dsc;
    logic [KEY_WIDTH-1:0] dq_key;
    logic acc, p_ok, sc_lt, hit_now, scan_end, out_free;

    assign pid_ext  = XW'(req.proc_id);
    assign p_idx    = pid_ext[PW-1:0];
    assign p_ok     = (32'(req.proc_id) < 32'(NUM_PROCS));
    assign key_ext  = YW'(req.sem_key);
    assign dq_key   = dq_reg[DW-1 -: KEY_WIDTH];
    assign dq_head  = dq_reg[PW +: PW];
    assign dq_tail  = dq_reg[0 +: PW];
    assign pq_nxt   = pq_reg[PW +: PW];
    assign pq_dsc   = pq_reg[0 +: PW];
    assign acc      = req.valid && (state_reg == ST_IDLE);
    assign sc_lt    = (sc_reg < CW'(NUM_PROCS));
    assign hit_now  = chk_vld_reg && active_reg[chk_reg] && (dq_key == key_reg);
    assign scan_end = chk_vld_reg && (chk_reg == PW'(NUM_PROCS - 1));
    assign out_free = !out_v_reg || rsp.ready;

    assign req.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = out_v_reg;
    assign rsp.proc_valid = out_pv_reg;
    assign rsp.out_proc   = out_p_reg;
    assign rsp.table_full = out_f_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    unique case (cmd_t'(req.cmd))
                        CMD_BLOCK:
                            state_next = (p_ok && !blocked_reg[p_idx]) ? ST_SCAN : ST_DONE;
                        CMD_CANCEL:
                            state_next = (p_ok && blocked_reg[p_idx]) ? ST_CX_RDP : ST_DONE;
                        CMD_WAKE, CMD_QUERY:
                            state_next = ST_SCAN;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (hit_now || scan_end)
                    state_next = ST_ACT;
            end
            ST_ACT:
            begin
                priority if (cmd_reg == CMD_BLOCK && (hit_reg || free_ok_reg))
                    state_next = ST_LINK;
                else if (cmd_reg == CMD_WAKE && hit_reg && head_reg != tail_reg)
                    state_next = ST_WAKE_NX;
                else
                    state_next = ST_DONE;
            end
            ST_LINK, ST_WAKE_NX:
                state_next = ST_DONE;
            ST_CX_RDP:
                state_next = ST_CX_RDD;
            ST_CX_RDD:
                state_next = (dq_head == p_reg) ? ST_DONE : ST_CX_WALK;
            ST_CX_WALK:
            begin
                if (pq_nxt == p_reg)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next     = cmd_reg;
        key_next     = key_reg;
        p_next       = p_reg;
        d_next       = d_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        pn_next      = pn_reg;
        q_next       = q_reg;
        chk_next     = chk_reg;
        chk_vld_next = 1'b0;
        sc_next      = sc_reg;
        free_ok_next = free_ok_reg;
        free_next    = free_reg;
        hit_next     = hit_reg;
        res_v_next   = res_v_reg;
        res_p_next   = res_p_reg;
        res_f_next   = res_f_reg;
        active_next  = active_reg;
        blocked_next = blocked_reg;
        out_pv_next  = out_pv_reg;
        out_p_next   = out_p_reg;
        out_f_next   = out_f_reg;
        out_v_next   = rsp.ready ? 1'b0 : out_v_reg;
        d_raddr      = '0;
        p_raddr      = '0;
        d_waddr      = d_reg;
        d_whead      = p_reg;
        d_wtail      = p_reg;
        d_we_key     = 1'b0;
        d_we_head    = 1'b0;
        d_we_tail    = 1'b0;
        p_waddr      = p_reg;
        p_wnxt       = p_reg;
        p_wdsc       = d_reg;
        p_we_nxt     = 1'b0;
        p_we_dsc     = 1'b0;
        res_ext      = XW'(res_p_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    cmd_next     = cmd_t'(req.cmd);
                    key_next     = key_ext[KEY_WIDTH-1:0];
                    p_next       = p_idx;
                    res_v_next   = 1'b0;
                    res_p_next   = '0;
                    res_f_next   = 1'b0;
                    sc_next      = '0;
                    free_ok_next = 1'b0;
                    hit_next     = 1'b0;
                    p_raddr      = p_idx;
                end
            end
            ST_SCAN:
            begin
                if (sc_lt)
                begin
                    d_raddr      = sc_reg[PW-1:0];
                    chk_vld_next = 1'b1;
                    chk_next     = sc_reg[PW-1:0];
                    sc_next      = sc_reg + CW'(1);
                end
                if (chk_vld_reg && !active_reg[chk_reg] && !free_ok_reg)
                begin
                    free_ok_next = 1'b1;
                    free_next    = chk_reg;
                end
                if (hit_now)
                begin
                    hit_next     = 1'b1;
                    d_next       = chk_reg;
                    head_next    = dq_head;
                    tail_next    = dq_tail;
                    chk_vld_next = 1'b0;
                end
            end
            ST_ACT:
            begin
                unique case (cmd_reg)
                    CMD_BLOCK:
                    begin
                        priority if (hit_reg)
                        begin
                            p_waddr   = tail_reg;
                            p_we_nxt  = 1'b1;
                            d_we_tail = 1'b1;
                        end
                        else if (free_ok_reg)
                        begin
                            d_waddr   = free_reg;
                            d_we_key  = 1'b1;
                            d_we_head = 1'b1;
                            d_we_tail = 1'b1;
                            d_next    = free_reg;
                            active_next[free_reg] = 1'b1;
                        end
                        else
                            res_f_next = 1'b1;
                    end
                    CMD_WAKE:
                    begin
                        if (hit_reg)
                        begin
                            res_v_next = 1'b1;
                            res_p_next = head_reg;
                            p_raddr    = head_reg;
                            if (head_reg == tail_reg)
                            begin
                                active_next[d_reg]     = 1'b0;
                                blocked_next[head_reg] = 1'b0;
                            end
                        end
                    end
                    CMD_QUERY:
                    begin
                        res_v_next = hit_reg;
                        res_p_next = hit_reg ? head_reg : '0;
                    end
                    CMD_CANCEL:
                    begin
                    end
                endcase
            end
            ST_LINK:
            begin
                p_we_dsc            = 1'b1;
                blocked_next[p_reg] = 1'b1;
            end
            ST_WAKE_NX:
            begin
                d_whead                = pq_nxt;
                d_we_head              = 1'b1;
                blocked_next[head_reg] = 1'b0;
            end
            ST_CX_RDP:
            begin
                d_next  = pq_dsc;
                pn_next = pq_nxt;
                d_raddr = pq_dsc;
            end
            ST_CX_RDD:
            begin
                tail_next = dq_tail;
                if (dq_head == p_reg)
                begin
                    if (dq_tail == p_reg)
                        active_next[d_reg] = 1'b0;
                    else
                    begin
                        d_whead   = pn_reg;
                        d_we_head = 1'b1;
                    end
                    blocked_next[p_reg] = 1'b0;
                    res_v_next          = 1'b1;
                    res_p_next          = p_reg;
                end
                else
                begin
                    p_raddr = dq_head;
                    q_next  = dq_head;
                end
            end
            ST_CX_WALK:
            begin
                if (pq_nxt == p_reg)
                begin
                    // unlink p from behind its predecessor
                    p_waddr  = q_reg;
                    p_wnxt   = pn_reg;
                    p_we_nxt = 1'b1;
                    if (tail_reg == p_reg)
                    begin
                        d_wtail   = q_reg;
                        d_we_tail = 1'b1;
                    end
                    blocked_next[p_reg] = 1'b0;
                    res_v_next          = 1'b1;
                    res_p_next          = p_reg;
                end
                else
                begin
                    p_raddr = pq_nxt;
                    q_next  = pq_nxt;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_v_next  = 1'b1;
                    out_pv_next = res_v_reg;
                    out_p_next  = res_ext[PROC_ID_W-1:0];
                    out_f_next  = res_f_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        dq_reg <= dmem[d_raddr];
        pq_reg <= pmem[p_raddr];
        if (d_we_key)
            dmem[d_waddr][DW-1 -: KEY_WIDTH] <= key_reg;
        if (d_we_head)
            dmem[d_waddr][PW +: PW] <= d_whead;
        if (d_we_tail)
            dmem[d_waddr][0 +: PW] <= d_wtail;
        if (p_we_nxt)
            pmem[p_waddr][PW +: PW] <= p_wnxt;
        if (p_we_dsc)
            pmem[p_waddr][0 +: PW] <= p_wdsc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            out_v_reg   <= 1'b0;
            chk_vld_reg <= 1'b0;
            active_reg  <= '0;
            blocked_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            out_v_reg   <= out_v_next;
            chk_vld_reg <= chk_vld_next;
            active_reg  <= active_next;
            blocked_reg <= blocked_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        p_reg       <= p_next;
        d_reg       <= d_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        pn_reg      <= pn_next;
        q_reg       <= q_next;
        chk_reg     <= chk_next;
        sc_reg      <= sc_next;
        free_ok_reg <= free_ok_next;
        free_reg    <= free_next;
        hit_reg     <= hit_next;
        res_v_reg   <= res_v_next;
        res_p_reg   <= res_p_next;
        res_f_reg   <= res_f_next;
        out_pv_reg  <= out_pv_next;
        out_p_reg   <= out_p_next;
        out_f_reg   <= out_f_next;
    end

endmodule
`default_nettype wire

>>> test/tb_semaphore_wait_queue_table.sv
// testbench: random semaphore block/wake/cancel/query traffic checked against a local table model
`default_nettype none
module tb_semaphore_wait_queue_table;
    import swqt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPROC = 32;

    typedef struct packed {
        cmd_t        cmd;
        logic [31:0] key;
        logic [4:0]  pid;
    } sem_op_t;

    typedef struct packed {
        logic       pvalid;
        logic [4:0] proc;
        logic       full;
    } sem_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    swqt_req_if req ();
    swqt_rsp_if rsp ();

    semaphore_wait_queue_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #1 clk = ~clk;

    // local copy of the descriptor pool and process links
    logic        m_active  [NPROC];
    logic [31:0] m_key     [NPROC];
    logic [4:0]  m_head    [NPROC];
    logic [4:0]  m_tail    [NPROC];
    logic [4:0]  m_next    [NPROC];
    logic        m_blocked [NPROC];
    logic [4:0]  m_desc    [NPROC];

    sem_op_t  pending_ops[$];
    sem_res_t expected_results[$];
    int       errors = 0;
    int       n_sent = 0;
    longint   cycles = 0;
    logic     gen_done = 1'b0;
    logic     long_hold = 1'b0;

    function automatic int find_desc(logic [31:0] k);
        for (int d = 0; d < NPROC; d++)
            if (m_active[d] && m_key[d] == k)
                return d;
        return NPROC;
    endfunction

    function automatic sem_res_t apply_op(sem_op_t op);
        sem_res_t r;
        int d;
        logic [4:0] q;
        r = '0;
        case (op.cmd)
            CMD_BLOCK:
            begin
                if (m_blocked[op.pid])
                    return r;
                d = find_desc(op.key);
                if (d == NPROC)
                begin
                    for (d = 0; d < NPROC; d++)
                        if (!m_active[d])
                            break;
                    if (d == NPROC)
                    begin
                        r.full = 1'b1;
                        return r;
                    end
                    m_active[d] = 1'b1;
                    m_key[d] = op.key;
                    m_head[d] = op.pid;
                    m_tail[d] = op.pid;
                end
                else
                begin
                    m_next[m_tail[d]] = op.pid;
                    m_tail[d] = op.pid;
                end
                m_blocked[op.pid] = 1'b1;
                m_desc[op.pid] = d[4:0];
            end
            CMD_WAKE:
            begin
                d = find_desc(op.key);
                if (d == NPROC)
                    return r;
                q = m_head[d];
                if (q == m_tail[d])
                    m_active[d] = 1'b0;
                else
                    m_head[d] = m_next[q];
                m_blocked[q] = 1'b0;
                r.pvalid = 1'b1;
                r.proc = q;
            end
            CMD_CANCEL:
            begin
                if (!m_blocked[op.pid])
                    return r;
                d = m_desc[op.pid];
                if (m_head[d] == op.pid)
                begin
                    if (m_tail[d] == op.pid)
                        m_active[d] = 1'b0;
                    else
                        m_head[d] = m_next[op.pid];
                end
                else
                begin
                    q = m_head[d];
                    for (int i = 0; i < NPROC; i++)
                    begin
                        if (m_next[q] == op.pid)
                        begin
                            m_next[q] = m_next[op.pid];
                            if (m_tail[d] == op.pid)
                                m_tail[d] = q;
                            break;
                        end
                        q = m_next[q];
                    end
                end
                m_blocked[op.pid] = 1'b0;
                r.pvalid = 1'b1;
                r.proc = op.pid;
            end
            default:
            begin
                d = find_desc(op.key);
                if (d < NPROC)
                begin
                    r.pvalid = 1'b1;
                    r.proc = m_head[d];
                end
            end
        endcase
        return r;
    endfunction

    function automatic sem_op_t make_op(cmd_t c, logic [31:0] k, logic [4:0] p);
        sem_op_t op;
        op.cmd = c;
        op.key = k;
        op.pid = p;
        return op;
    endfunction

    // keys drawn from a small pool so queues grow, with some wide random keys
    function automatic logic [31:0] pick_key(int pool);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return 32'h1000_0000 + 32'($urandom_range(0, pool - 1)) * 4;
    endfunction

    // driver: bursts of random length with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
        end
        else if (!req.valid || req.ready)
        begin
            if (req.valid)
                n_sent <= n_sent + 1;
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                req.valid <= 1'b0;
            end
            else if (pending_ops.size() > 0)
            begin
                sem_op_t op;
                op = pending_ops.pop_front();
                req.valid   <= 1'b1;
                req.cmd     <= op.cmd;
                req.sem_key <= op.key;
                req.proc_id <= op.pid;
                if (burst_left > 0)
                    burst_left <= burst_left - 1;
                else
                begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                req.valid <= 1'b0;
        end
    end

    // predict on each accepted command beat
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            expected_results.push_back(apply_op(make_op(cmd_t'(req.cmd), req.sem_key,
                                                        req.proc_id)));
    end

    // receiver stall pattern
    int stall_phase = 0;
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else
        begin
            stall_phase <= (stall_phase + 1) % 23;
            if (long_hold)
                rsp.ready <= 1'b0;
            else if (stall_phase < 8)
                rsp.ready <= 1'b1;
            else
                rsp.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat pv=%b proc=%0d full=%b", $time,
                         rsp.proc_valid, rsp.out_proc, rsp.table_full);
                errors <= errors + 1;
            end
            else
            begin
                sem_res_t e;
                e = expected_results.pop_front();
                if (rsp.proc_valid !== e.pvalid)
                begin
                    $display("%0t: proc_valid expected %b actual %b", $time, e.pvalid,
                             rsp.proc_valid);
                    errors <= errors + 1;
                end
                if (rsp.out_proc !== e.proc)
                begin
                    $display("%0t: out_proc expected %0d actual %0d", $time, e.proc,
                             rsp.out_proc);
                    errors <= errors + 1;
                end
                if (rsp.table_full !== e.full)
                begin
                    $display("%0t: table_full expected %b actual %b", $time, e.full,
                             rsp.table_full);
                    errors <= errors + 1;
                end
            end
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("** semaphore_wait_queue_table: FAILED **");
            $finish;
        end
    end

    // long receiver hold-off while the sender keeps offering
    initial
    begin
        repeat (3000) @(posedge clk);
        long_hold <= 1'b1;
        repeat (400) @(posedge clk);
        long_hold <= 1'b0;
    end

    int n_total;
    initial
    begin
        req.valid = 1'b0;
        req.cmd = CMD_BLOCK;
        req.sem_key = '0;
        req.proc_id = '0;
        rsp.ready = 1'b0;
        for (int i = 0; i < NPROC; i++)
        begin
            m_active[i] = 1'b0;
            m_blocked[i] = 1'b0;
            m_key[i] = '0;
            m_head[i] = '0;
            m_tail[i] = '0;
            m_next[i] = '0;
            m_desc[i] = '0;
        end

        // directed: misses on an empty table, key extremes, queue of three, cancels
        pending_ops.push_back(make_op(CMD_WAKE, 32'h0, 5'd0));
        pending_ops.push_back(make_op(CMD_QUERY, 32'hFFFF_FFFF, 5'd0));
        pending_ops.push_back(make_op(CMD_CANCEL, 32'h0, 5'd31));
        pending_ops.push_back(make_op(CMD_BLOCK, 32'h0, 5'd0));
        pending_ops.push_back(make_op(CMD_BLOCK, 32'hFFFF_FFFF, 5'd31));
        pending_ops.push_back(make_op(CMD_BLOCK, 32'h0, 5'd0));
        pending_ops.push_back(make_op(CMD_BLOCK, 32'h0, 5'd5));
        pending_ops.push_back(make_op(CMD_BLOCK, 32'h0, 5'd9));
        pending_ops.push_back(make_op(CMD_QUERY, 32'h0, 5'd0));
        pending_ops.push_back(make_op(CMD_CANCEL, 32'h0, 5'd5));
        pending_ops.push_back(make_op(CMD_CANCEL, 32'h0, 5'd9));
        pending_ops.push_back(make_op(CMD_WAKE, 32'h0, 5'd0));
        pending_ops.push_back(make_op(CMD_WAKE, 32'h0, 5'd0));
        pending_ops.push_back(make_op(CMD_QUERY, 32'hFFFF_FFFF, 5'd0));
        pending_ops.push_back(make_op(CMD_CANCEL, 32'h0, 5'd31));
        pending_ops.push_back(make_op(CMD_QUERY, 32'hFFFF_FFFF, 5'd0));
        // all 32 processes on distinct keys fill every descriptor; this cannot
        // overflow since a blocked process cannot block again
        for (int i = 0; i < NPROC; i++)
            pending_ops.push_back(make_op(CMD_BLOCK, 32'hA000_0000 + i, 5'(i)));
        pending_ops.push_back(make_op(CMD_BLOCK, 32'hB000_0000, 5'd3));
        for (int i = 0; i < NPROC; i++)
            pending_ops.push_back(make_op(CMD_WAKE, 32'hA000_0000 + i, 5'd0));

        // random traffic
        n_total = pending_ops.size() + 1650;
        while (pending_ops.size() < n_total)
        begin
            int w;
            w = $urandom_range(0, 99);
            if (w < 40)
                pending_ops.push_back(make_op(CMD_BLOCK, pick_key(6), 5'($urandom)));
            else if (w < 65)
                pending_ops.push_back(make_op(CMD_WAKE, pick_key(6), 5'($urandom)));
            else if (w < 85)
                pending_ops.push_back(make_op(CMD_CANCEL, $urandom, 5'($urandom)));
            else
                pending_ops.push_back(make_op(CMD_QUERY, pick_key(6), 5'($urandom)));
        end
        n_total = pending_ops.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (n_sent < n_total || expected_results.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("** semaphore_wait_queue_table: PASSED **");
        else
            $display("** semaphore_wait_queue_table: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
